// File: hw/rtl/luminance_range_rgb_to_bytes_unit_assert.svh
// Assertion macros for the luminance range to bytes unit.
// Included by luminance_range_rgb_to_bytes_unit, the RTL module that carries concurrent checks.
`ifndef LUMINANCE_RANGE_RGB_TO_BYTES_UNIT_ASSERT_SVH
`define LUMINANCE_RANGE_RGB_TO_BYTES_UNIT_ASSERT_SVH

// same-cycle implication
`define LUMRNG_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LUMRNG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/lumrng_pkg.sv
// Shared types and constants of the luminance range to bytes unit.
// No dependencies.
package lumrng_pkg;

   localparam int NUM_CH    = 3;
   localparam int QUOT_BITS = 8;

   typedef logic [1:0] csr_index_type;

   localparam csr_index_type REG_BLACK_LEVEL   = 2'd0;
   localparam csr_index_type REG_WHITE_LEVEL   = 2'd1;
   localparam csr_index_type REG_USE_MEAS_BLK  = 2'd2;
   localparam csr_index_type REG_USE_MEAS_WHT  = 2'd3;

   localparam logic MODE_MEASURE = 1'b0;
   localparam logic MODE_CONVERT = 1'b1;

endpackage

// File: hw/rtl/luminance_range_rgb_to_bytes_unit.sv
// Min/max contrast stretch of RGB pixels to bytes, bit-serial multiply and divide.
// Depends on lumrng_pkg and luminance_range_rgb_to_bytes_unit_assert.svh.
// Measure beat: no response; a new beat can be accepted every clock.
// Convert beat: states PREP, MUL, SCALE, DIV, then DONE until the response register is free;
// PREP skips to DONE when the range is empty or the pixel black; next beat accepted after the handoff.
// Synchronous reset: idle, levels at their defaults, measured range emptied.
module luminance_range_rgb_to_bytes_unit #(
   parameter int COMPONENT_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_mode,
   input  logic                               req_first,
   input  logic [COMPONENT_BITS-1:0]          req_red_in,
   input  logic [COMPONENT_BITS-1:0]          req_green_in,
   input  logic [COMPONENT_BITS-1:0]          req_blue_in,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [lumrng_pkg::QUOT_BITS-1:0]   rsp_red_out,
   output logic [lumrng_pkg::QUOT_BITS-1:0]   rsp_green_out,
   output logic [lumrng_pkg::QUOT_BITS-1:0]   rsp_blue_out,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  lumrng_pkg::csr_index_type          csr_index,
   input  logic [COMPONENT_BITS+1:0]          csr_data
);

`include "luminance_range_rgb_to_bytes_unit_assert.svh"

   localparam int CB = COMPONENT_BITS;
   localparam int LB = COMPONENT_BITS + 2;
   localparam int PW = CB + LB;
   localparam int RW = PW + lumrng_pkg::QUOT_BITS;
   localparam int CW = $clog2(LB + 1);
   localparam int QB = lumrng_pkg::QUOT_BITS;
   localparam int NC = lumrng_pkg::NUM_CH;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PREP  = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_SCALE = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   localparam logic [LB-1:0] WHITE_RESET = LB'(196605);

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [LB-1:0] black_ff, black_in, white_ff, white_in;
   logic          use_blk_ff, use_blk_in, use_wht_ff, use_wht_in;
   logic [LB-1:0] min_ff, min_in, max_ff, max_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [QB-1:0] out_ff [NC];
   logic [QB-1:0] out_in [NC];

   logic [CB-1:0] c_ff [NC];
   logic [CB-1:0] c_in [NC];
   logic [LB-1:0] lum_ff, lum_in;
   logic [CB-1:0] maxc_ff, maxc_in;
   logic [LB-1:0] sn_ff, sn_in, sd_ff, sd_in;
   logic [PW-1:0] den_ff, den_in;
   logic [RW-1:0] dsr_ff, dsr_in;
   logic [RW-1:0] rem_ff [NC];
   logic [RW-1:0] rem_in [NC];
   logic [QB-1:0] q_ff [NC];
   logic [QB-1:0] q_in [NC];

   logic          req_take, out_free;
   logic [LB-1:0] req_lum, base_min, base_max;
   logic [LB-1:0] lo, hi, lum_cl;
   logic [CB-1:0] max_rg;
   logic          ge [NC];

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   assign req_lum  = LB'(req_red_in) + LB'(req_green_in) + LB'(req_blue_in);
   assign base_min = req_first ? {LB{1'b1}} : min_ff;
   assign base_max = req_first ? '0 : max_ff;

   assign lo     = use_blk_ff ? min_ff : black_ff;
   assign hi     = use_wht_ff ? max_ff : white_ff;
   assign max_rg = (c_ff[1] > c_ff[0]) ? c_ff[1] : c_ff[0];
   assign lum_cl = (lum_ff < lo) ? lo : ((lum_ff > hi) ? hi : lum_ff);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      black_in     = black_ff;
      white_in     = white_ff;
      use_blk_in   = use_blk_ff;
      use_wht_in   = use_wht_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      rsp_valid_in = rsp_valid_ff;
      lum_in       = lum_ff;
      maxc_in      = maxc_ff;
      sn_in        = sn_ff;
      sd_in        = sd_ff;
      den_in       = den_ff;
      dsr_in       = dsr_ff;
      for (int k = 0; k < NC; k++) begin
         c_in[k]   = c_ff[k];
         rem_in[k] = rem_ff[k];
         q_in[k]   = q_ff[k];
         out_in[k] = out_ff[k];
         ge[k]     = rem_ff[k] >= dsr_ff;
      end

      if (csr_valid && csr_ready) begin
         case (csr_index)
            lumrng_pkg::REG_BLACK_LEVEL:  black_in   = csr_data;
            lumrng_pkg::REG_WHITE_LEVEL:  white_in   = csr_data;
            lumrng_pkg::REG_USE_MEAS_BLK: use_blk_in = csr_data[0];
            lumrng_pkg::REG_USE_MEAS_WHT: use_wht_in = csr_data[0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_mode == lumrng_pkg::MODE_MEASURE) begin
                  min_in = (req_lum < base_min) ? req_lum : base_min;
                  max_in = (req_lum > base_max) ? req_lum : base_max;
               end else begin
                  c_in[0]  = req_red_in;
                  c_in[1]  = req_green_in;
                  c_in[2]  = req_blue_in;
                  lum_in   = req_lum;
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            maxc_in = (c_ff[2] > max_rg) ? c_ff[2] : max_rg;
            sn_in   = lum_cl - lo;
            sd_in   = hi - lo;
            den_in  = '0;
            cnt_in  = CW'(LB - 1);
            for (int k = 0; k < NC; k++) begin
               rem_in[k] = '0;
               q_in[k]   = '0;
            end
            if (hi <= lo || maxc_in == '0) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            for (int k = 0; k < NC; k++) begin
               rem_in[k] = {rem_ff[k][RW-2:0], 1'b0}
                         + (sn_ff[LB-1] ? {{(RW-CB){1'b0}}, c_ff[k]} : '0);
            end
            den_in = {den_ff[PW-2:0], 1'b0}
                   + (sd_ff[LB-1] ? {{LB{1'b0}}, maxc_ff} : '0);
            sn_in  = {sn_ff[LB-2:0], 1'b0};
            sd_in  = {sd_ff[LB-2:0], 1'b0};
            if (cnt_ff == '0) begin
               state_in = ST_SCALE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_SCALE: begin
            for (int k = 0; k < NC; k++) begin
               rem_in[k] = {rem_ff[k][RW-QB-1:0], {QB{1'b0}}} - rem_ff[k];
            end
            dsr_in   = {1'b0, den_ff, {(QB-1){1'b0}}};
            cnt_in   = CW'(QB - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            for (int k = 0; k < NC; k++) begin
               rem_in[k] = ge[k] ? (rem_ff[k] - dsr_ff) : rem_ff[k];
               q_in[k]   = {q_ff[k][QB-2:0], ge[k]};
            end
            dsr_in = {1'b0, dsr_ff[RW-1:1]};
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               for (int k = 0; k < NC; k++) begin
                  out_in[k] = q_ff[k];
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         black_ff     <= '0;
         white_ff     <= WHITE_RESET;
         use_blk_ff   <= 1'b1;
         use_wht_ff   <= 1'b1;
         min_ff       <= {LB{1'b1}};
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         black_ff     <= black_in;
         white_ff     <= white_in;
         use_blk_ff   <= use_blk_in;
         use_wht_ff   <= use_wht_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lum_ff  <= lum_in;
      maxc_ff <= maxc_in;
      sn_ff   <= sn_in;
      sd_ff   <= sd_in;
      den_ff  <= den_in;
      dsr_ff  <= dsr_in;
      for (int k = 0; k < NC; k++) begin
         c_ff[k]   <= c_in[k];
         rem_ff[k] <= rem_in[k];
         q_ff[k]   <= q_in[k];
         out_ff[k] <= out_in[k];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = out_ff[0];
   assign rsp_green_out = out_ff[1];
   assign rsp_blue_out  = out_ff[2];

   `LUMRNG_ASSERT_NEXT(a_restart_single, clock, reset, req_take && req_mode == lumrng_pkg::MODE_MEASURE && req_first, min_ff == max_ff, "restart did not seed range from one pixel")
   `LUMRNG_ASSERT_IMPLY(a_div_bound, clock, reset, state_ff == ST_DIV, rem_ff[0] < {dsr_ff[RW-2:0], 1'b0}, "partial remainder exceeds quotient range")
   `LUMRNG_ASSERT_NEXT(a_mul_exit, clock, reset, state_ff == ST_MUL, state_ff == ST_MUL || state_ff == ST_SCALE, "multiply phase left early")
   `LUMRNG_ASSERT_IMPLY(a_div_count, clock, reset, state_ff == ST_DIV, cnt_ff < CW'(QB), "divide step count out of range")

endmodule

// File: tb/sv/tb_luminance_range_rgb_to_bytes_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for luminance_range_rgb_to_bytes_unit: a directed table, then
// random measure/convert beats under several level settings, checked by a local predictor.
// Depends on lumrng_pkg and the unit's RTL.
module tb_luminance_range_rgb_to_bytes_unit;

   localparam int CB            = 16;
   localparam int LUM_W         = CB + 2;
   localparam int QB            = lumrng_pkg::QUOT_BITS;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 300;

   typedef struct packed {
      logic [QB-1:0] red;
      logic [QB-1:0] green;
      logic [QB-1:0] blue;
   } rgb_bytes_type;

   typedef struct packed {
      logic          mode;
      logic          first;
      logic [CB-1:0] red;
      logic [CB-1:0] green;
      logic [CB-1:0] blue;
      logic          pinned;
      rgb_bytes_type want;
   } pixel_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_mode = lumrng_pkg::MODE_MEASURE;
   logic                      req_first = 1'b0;
   logic [CB-1:0]             req_red_in = '0;
   logic [CB-1:0]             req_green_in = '0;
   logic [CB-1:0]             req_blue_in = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [QB-1:0]             rsp_red_out;
   logic [QB-1:0]             rsp_green_out;
   logic [QB-1:0]             rsp_blue_out;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   lumrng_pkg::csr_index_type csr_index = lumrng_pkg::REG_BLACK_LEVEL;
   logic [LUM_W-1:0]          csr_data = '0;

   pixel_row_type             offered_row = '0;

   // predictor state and level registers
   logic [LUM_W-1:0]          meas_min = '1;
   logic [LUM_W-1:0]          meas_max = '0;
   logic [LUM_W-1:0]          cfg_black = '0;
   logic [LUM_W-1:0]          cfg_white = 18'd196605;
   logic                      cfg_use_black = 1'b1;
   logic                      cfg_use_white = 1'b1;

   rgb_bytes_type             expected_bytes [$];
   int                        mismatch_count = 0;
   bit                        tx_idle_en = 1'b1;
   bit                        rx_idle_en = 1'b1;
   int                        hold_requests = 0;
   int                        holds_served = 0;

   luminance_range_rgb_to_bytes_unit #(.COMPONENT_BITS(CB)) dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [QB-1:0] stretch_channel(input logic [CB-1:0] c,
      input logic [CB-1:0] maxc, input logic [LUM_W-1:0] span,
      input logic [LUM_W-1:0] span_range);
      longint unsigned num;
      longint unsigned den;
      longint unsigned q;
      num = 64'd255 * 64'(c) * 64'(span);
      den = 64'(maxc) * 64'(span_range);
      if (den == 0) return '0;
      q = num / den;
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   // advances the measured range; returns 1 when the beat yields a result
   function automatic bit stretch_pixel(input pixel_row_type p, output rgb_bytes_type o);
      logic [LUM_W-1:0] lum;
      logic [LUM_W-1:0] lo;
      logic [LUM_W-1:0] hi;
      logic [LUM_W-1:0] l;
      logic [CB-1:0]    maxc;
      lum = LUM_W'(p.red) + LUM_W'(p.green) + LUM_W'(p.blue);
      o = '0;
      if (p.mode == lumrng_pkg::MODE_MEASURE) begin
         if (p.first) begin
            meas_min = '1;
            meas_max = '0;
         end
         if (lum > meas_max) meas_max = lum;
         if (lum < meas_min) meas_min = lum;
         return 1'b0;
      end
      lo = cfg_use_black ? meas_min : cfg_black;
      hi = cfg_use_white ? meas_max : cfg_white;
      maxc = p.red;
      if (p.green > maxc) maxc = p.green;
      if (p.blue > maxc) maxc = p.blue;
      if (hi <= lo || maxc == '0) return 1'b1;
      l = lum;
      if (l < lo) l = lo;
      if (l > hi) l = hi;
      o.red   = stretch_channel(p.red, maxc, l - lo, hi - lo);
      o.green = stretch_channel(p.green, maxc, l - lo, hi - lo);
      o.blue  = stretch_channel(p.blue, maxc, l - lo, hi - lo);
      return 1'b1;
   endfunction

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t mismatch: %s", $time, msg);
   endtask

   always @(posedge clock) begin
      rgb_bytes_type predicted;
      rgb_bytes_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               lumrng_pkg::REG_BLACK_LEVEL:  cfg_black = csr_data;
               lumrng_pkg::REG_WHITE_LEVEL:  cfg_white = csr_data;
               lumrng_pkg::REG_USE_MEAS_BLK: cfg_use_black = csr_data[0];
               lumrng_pkg::REG_USE_MEAS_WHT: cfg_use_white = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (stretch_pixel(offered_row, predicted))
               expected_bytes.push_back(offered_row.pinned ? offered_row.want : predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               flag_mismatch($sformatf("result %0d/%0d/%0d with nothing expected",
                  rsp_red_out, rsp_green_out, rsp_blue_out));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_red_out !== want.red)
                  flag_mismatch($sformatf("red exp %0d got %0d", want.red, rsp_red_out));
               if (rsp_green_out !== want.green)
                  flag_mismatch($sformatf("green exp %0d got %0d", want.green, rsp_green_out));
               if (rsp_blue_out !== want.blue)
                  flag_mismatch($sformatf("blue exp %0d got %0d", want.blue, rsp_blue_out));
            end
         end
      end
   end

   // result side: random stall bursts, one long hold-off on request
   initial begin : rsp_side
      forever begin
         if (holds_served < hold_requests) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_served++;
         end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_pixel(input pixel_row_type row);
      if (tx_idle_en && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_mode     <= row.mode;
      req_first    <= row.first;
      req_red_in   <= row.red;
      req_green_in <= row.green;
      req_blue_in  <= row.blue;
      offered_row  <= row;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic await_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_levels(input logic [LUM_W-1:0] black, input logic [LUM_W-1:0] white,
      input logic use_blk, input logic use_wht);
      lumrng_pkg::csr_index_type idx [4];
      logic [LUM_W-1:0]          val [4];
      int                        k;
      idx = '{lumrng_pkg::REG_BLACK_LEVEL, lumrng_pkg::REG_WHITE_LEVEL,
              lumrng_pkg::REG_USE_MEAS_BLK, lumrng_pkg::REG_USE_MEAS_WHT};
      val = '{black, white, {{(LUM_W-1){1'b0}}, use_blk}, {{(LUM_W-1){1'b0}}, use_wht}};
      for (k = 0; k < 4; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_data  <= val[k];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [CB-1:0] pick_component();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return CB'($urandom_range(1, 255));
         default: return CB'($urandom);
      endcase
   endfunction

   // random beats: occasional restarts, measure beats and mostly converts
   task automatic run_pixels(input int count);
      pixel_row_type row;
      int            k;
      int            pick;
      for (k = 0; k < count; k++) begin
         row = '0;
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            row.mode  = lumrng_pkg::MODE_MEASURE;
            row.first = 1'b1;
         end else if (pick < 8) begin
            row.mode  = lumrng_pkg::MODE_MEASURE;
            row.first = ($urandom_range(0, 29) == 0);
         end else begin
            row.mode  = lumrng_pkg::MODE_CONVERT;
            row.first = 1'($urandom_range(0, 1));
         end
         row.red   = pick_component();
         row.green = pick_component();
         row.blue  = pick_component();
         if ($urandom_range(0, 149) == 0) await_idle();
         send_pixel(row);
      end
   endtask

   pixel_row_type directed_rows [0:21] = '{
      '{lumrng_pkg::MODE_CONVERT, 1'b0, 16'd1000, 16'd2000, 16'd3000, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{lumrng_pkg::MODE_MEASURE, 1'b1, 16'd0, 16'd0, 16'd0, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{lumrng_pkg::MODE_MEASURE, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{lumrng_pkg::MODE_CONVERT, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
        '{8'd255, 8'd255, 8'd255}},
      '{lumrng_pkg::MODE_CONVERT, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{lumrng_pkg::MODE_CONVERT, 1'b0, 16'hFFFF, 16'd0, 16'd0, 1'b1, '{8'd85, 8'd0, 8'd0}},
      '{lumrng_pkg::MODE_CONVERT, 1'b0, 16'd0, 16'hFFFF, 16'd0, 1'b1, '{8'd0, 8'd85, 8'd0}},
      '{lumrng_pkg::MODE_CONVERT, 1'b0, 16'd0, 16'd0, 16'hFFFF, 1'b1, '{8'd0, 8'd0, 8'd85}},
      '{lumrng_pkg::MODE_CONVERT, 1'b0, 16'd1, 16'd0, 16'd0, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{lumrng_pkg::MODE_MEASURE, 1'b1, 16'd1000, 16'd1000, 16'd1000, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{lumrng_pkg::MODE_CONVERT, 1'b0, 16'd1000, 16'd1000, 16'd1000, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{lumrng_pkg::MODE_MEASURE, 1'b0, 16'd2000, 16'd2000, 16'd2000, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{lumrng_pkg::MODE_MEASURE, 1'b0, 16'd500, 16'd500, 16'd500, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{lumrng_pkg::MODE_CONVERT, 1'b0, 16'd100, 16'd100, 16'd100, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{lumrng_pkg::MODE_CONVERT, 1'b0, 16'd3000, 16'd3000, 16'd3000, 1'b1,
        '{8'd255, 8'd255, 8'd255}},
      '{lumrng_pkg::MODE_CONVERT, 1'b1, 16'd1234, 16'd567, 16'd890, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{lumrng_pkg::MODE_CONVERT, 1'b0, 16'd1500, 16'd1000, 16'd500, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{lumrng_pkg::MODE_MEASURE, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{lumrng_pkg::MODE_CONVERT, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{lumrng_pkg::MODE_MEASURE, 1'b0, 16'd0, 16'd0, 16'd1, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{lumrng_pkg::MODE_CONVERT, 1'b0, 16'hFFFF, 16'hFFFF, 16'd0, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{lumrng_pkg::MODE_CONVERT, 1'b0, 16'hAAAA, 16'h5555, 16'h8001, 1'b0, '{8'd0, 8'd0, 8'd0}}
   };

   initial begin : stimulus
      logic [LUM_W-1:0] lvl_a;
      logic [LUM_W-1:0] lvl_b;
      int               spin;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) send_pixel(directed_rows[i]);
      await_idle();

      // levels after reset, with the output held off long enough to back up the input
      hold_requests++;
      run_pixels(150);
      await_idle();

      write_levels(18'd0, 18'd196605, 1'b0, 1'b0);
      run_pixels(150);
      await_idle();

      // inverted range: every convert yields zero
      write_levels('1, 18'd0, 1'b0, 1'b0);
      run_pixels(60);
      await_idle();

      write_levels(18'd0, '1, 1'b0, 1'b0);
      run_pixels(150);
      await_idle();

      lvl_a = LUM_W'($urandom_range(0, 196605));
      write_levels(lvl_a, LUM_W'($urandom_range(0, 262143)), 1'b0, 1'b1);
      run_pixels(150);
      await_idle();

      lvl_b = LUM_W'($urandom_range(0, 262143));
      write_levels(LUM_W'($urandom_range(0, 262143)), lvl_b, 1'b1, 1'b0);
      run_pixels(150);
      await_idle();

      lvl_a = LUM_W'($urandom_range(0, 196604));
      write_levels(lvl_a, LUM_W'($urandom_range(lvl_a + 1, 196605)), 1'b0, 1'b0);
      run_pixels(150);
      await_idle();

      // flat configured range
      write_levels(lvl_a, lvl_a, 1'b0, 1'b0);
      run_pixels(50);
      await_idle();

      write_levels(LUM_W'($urandom), LUM_W'($urandom), 1'($urandom_range(0, 1)),
         1'($urandom_range(0, 1)));
      run_pixels(150);
      await_idle();

      write_levels(18'd0, 18'd196605, 1'b1, 1'b1);
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b0;
      run_pixels(200);

      req_valid <= 1'b0;
      @(posedge clock);
      spin = 0;
      while (expected_bytes.size() != 0 && spin < 20000) begin
         @(posedge clock);
         spin++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_bytes.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", expected_bytes.size()));

      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
